>>> sv/fair_share_task_picker_assert.svh
// Assertion macros shared by the fair-share task picker RTL.
// No dependencies; simulation-only checks compile away when SYNTH is defined.
`ifndef FAIR_SHARE_TASK_PICKER_ASSERT_SVH
`define FAIR_SHARE_TASK_PICKER_ASSERT_SVH

`ifndef SYNTH
// Clocked check that is ignored while reset is held.
`define FSTP_ASSERT_RST(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
// Clocked check that also holds during reset.
`define FSTP_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define FSTP_ASSERT_RST(label, clk_sig, rst_sig, prop, msg)
`define FSTP_ASSERT_ALWAYS(label, clk_sig, prop, msg)
`endif

`endif

>>> sv/fstp_pkg.sv
// Shared types, sizes and helpers for the fair-share task picker.
// No dependencies; used by fstp_cell and fair_share_task_picker.
package fstp_pkg;

  // Number of task entries in the ring of cells.
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int SLICE_W   = 4;
  localparam int PROD_W    = SLICE_W + CNT_W;
  localparam int DATA_W    = 32;

  typedef logic signed [DATA_W-1:0] owed_t;
  typedef logic [DATA_W-1:0]        run_t;
  typedef logic [IDX_W-1:0]         idx_t;

  // Control beat sent from the head of the ring to every cell.
  typedef struct packed {
    logic  shift;
    logic  wr;
    idx_t  idx;
    owed_t owed;
    run_t  run;
  } fstp_ctl_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic owed_t sat_s32(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W+1:0] hi;
    logic signed [DATA_W+1:0] lo;
    hi = (DATA_W+2)'($signed({1'b0, {(DATA_W-1){1'b1}}}));
    lo = -hi - (DATA_W+2)'(1);
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> sv/fstp_cell.sv
// One task entry of the fair-share picker ring: owed time and run total.
// Depends on fstp_pkg for the data types and the control beat.
module fstp_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  fstp_pkg::fstp_ctl_t  ctl,
  input  fstp_pkg::idx_t       cell_idx,
  input  fstp_pkg::owed_t      in_owed,
  input  fstp_pkg::run_t       in_run,
  output fstp_pkg::owed_t      owed,
  output fstp_pkg::run_t       run
);
  import fstp_pkg::*;

  // The entry either takes its neighbor's contents during a scan rotation,
  // or loads the final update when the head addresses this cell's home slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
      run  <= '0;
    end else if (ctl.shift) begin
      owed <= in_owed;
      run  <= in_run;
    end else if (ctl.wr && (ctl.idx == cell_idx)) begin
      owed <= ctl.owed;
      run  <= ctl.run;
    end
  end

endmodule

>>> sv/fair_share_task_picker.sv
// Top level of the fair-share task picker: ring of task cells plus head logic.
// Depends on fstp_pkg, fstp_cell and fair_share_task_picker_assert.svh.
//
// Usage:
//   Configuration: cfg_we with cfg_data writes active_tasks (reset 10). A value
//   of 0 counts as one task, a value above the table size as the full table.
//   Write it only while the block is idle.
//   Input: a scheduling beat is taken at a rising edge where start is high and
//   busy is low; slice_length is sampled at that edge.
//   Output: done pulses for one cycle with granted_task, granted_slice and
//   task_run_total. The receiver cannot stall, so nothing waits on it.
//   Sequence: the task entries rotate once around the ring of cells, one
//   entry per cycle past the head, in the scan state; the write-back state
//   then writes the chosen task back to its cell. busy is high through the
//   scan and the write-back, and done is shown in the first cycle with busy
//   low. A new beat can be taken at the edge that ends that cycle, but not
//   before the block is through with the last beat.
//   Reset: synchronous rst clears all owed times and run totals at once and
//   sets the active count to 10; no clearing pass is needed.
`include "fair_share_task_picker_assert.svh"

module fair_share_task_picker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        start,
  input  logic [3:0]  slice_length,
  output logic        busy,
  output logic        done,
  output logic [3:0]  granted_task,
  output logic [3:0]  granted_slice,
  output logic [31:0] task_run_total
);
  import fstp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]          state;
  logic [4:0]          active_tasks;
  logic [CNT_W-1:0]    n_cur;
  logic [CNT_W-1:0]    n_q;
  logic [SLICE_W-1:0]  slice_q;
  logic [PROD_W-1:0]   prod_q;
  idx_t                scan_idx;
  owed_t               best;
  idx_t                pick;
  owed_t               pick_owed;
  run_t                pick_run;
  logic                in_range;
  owed_t               head_owed_wb;
  owed_t               new_owed;
  run_t                new_run;
  logic [DATA_W:0]     run_sum;
  fstp_ctl_t           ctl;
  owed_t               owed_q [MAX_TASKS];
  run_t                run_q  [MAX_TASKS];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_tasks <= 5'd10;
    end else if (cfg_we) begin
      active_tasks <= cfg_data;
    end
  end

  // Clamp the active count to the range one to MAX_TASKS.
  always_comb begin
    if (active_tasks == 5'd0) begin
      n_cur = CNT_W'(1);
    end else if (32'(active_tasks) > 32'(MAX_TASKS)) begin
      n_cur = CNT_W'(MAX_TASKS);
    end else begin
      n_cur = CNT_W'(active_tasks);
    end
  end

  assign busy = (state != ST_IDLE);

  // Head of the ring: the entry in cell 0 is examined and written back to the
  // tail with the slice added when it belongs to an active task.
  assign in_range     = (CNT_W'(scan_idx) < n_q);
  assign head_owed_wb = in_range
                        ? sat_s32((DATA_W+2)'(owed_q[0]) + (DATA_W+2)'(slice_q))
                        : owed_q[0];

  // Final values for the chosen task, computed exactly and saturated once.
  assign new_owed = sat_s32((DATA_W+2)'(pick_owed) + (DATA_W+2)'(slice_q)
                            - (DATA_W+2)'(prod_q));
  assign run_sum  = {1'b0, pick_run} + (DATA_W+1)'(slice_q);
  assign new_run  = run_sum[DATA_W] ? {DATA_W{1'b1}} : run_sum[DATA_W-1:0];

  // Control beat broadcast to the cells.
  always_comb begin
    ctl.shift = (state == ST_SCAN);
    ctl.wr    = (state == ST_WRITE);
    ctl.idx   = pick;
    ctl.owed  = new_owed;
    ctl.run   = new_run;
  end

  // Ring of cells: each cell takes its upper neighbor, the last takes the head.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    owed_t in_owed_w;
    run_t  in_run_w;
    if (i == MAX_TASKS - 1) begin : g_tail
      assign in_owed_w = head_owed_wb;
      assign in_run_w  = run_q[0];
    end else begin : g_mid
      assign in_owed_w = owed_q[i+1];
      assign in_run_w  = run_q[i+1];
    end
    fstp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .cell_idx (IDX_W'(i)),
      .in_owed  (in_owed_w),
      .in_run   (in_run_w),
      .owed     (owed_q[i]),
      .run      (run_q[i])
    );
  end

  // Sequencer: accept, rotate once around the ring, then write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state    <= ST_SCAN;
            scan_idx <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_idx == IDX_W'(MAX_TASKS - 1)) begin
            state    <= ST_WRITE;
            scan_idx <= '0;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item registers and the running best during the scan.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      slice_q <= slice_length;
      n_q     <= n_cur;
      prod_q  <= PROD_W'(slice_length) * PROD_W'(n_cur);
      best    <= '1;
      pick    <= '0;
    end else if (state == ST_SCAN) begin
      if (in_range && (owed_q[0] > best)) begin
        best      <= owed_q[0];
        pick      <= scan_idx;
        pick_owed <= owed_q[0];
        pick_run  <= run_q[0];
      end else if (scan_idx == '0) begin
        // Task 0 is the default grant, so its entry is always captured.
        pick_owed <= owed_q[0];
        pick_run  <= run_q[0];
      end
    end
  end

  // Result registers, loaded in the write-back state and shown with done.
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      granted_task   <= 4'(pick);
      granted_slice  <= slice_q;
      task_run_total <= new_run;
    end
  end

  `FSTP_ASSERT_RST(a_done_after_write, clk, rst,
                   done |-> ($past(state) == ST_WRITE), "done without a write-back cycle")
  `FSTP_ASSERT_RST(a_start_sets_busy, clk, rst,
                   (start && !busy) |=> busy, "accepted beat did not raise busy")
  `FSTP_ASSERT_ALWAYS(a_idx_idle, clk,
                      (state != ST_SCAN) |-> (scan_idx == '0), "scan index left over outside a scan")
  `FSTP_ASSERT_RST(a_done_idle, clk, rst, done |-> !busy, "done shown while still busy")

endmodule

>>> dv/fair_share_task_picker_tb.sv
// Self-checking testbench for fair_share_task_picker: scheduling beats with random slices
// over several active-task counts, each grant checked against an internal fair-share model.
// Depends on fstp_pkg and the fair_share_task_picker RTL.
module fair_share_task_picker_tb;
  import fstp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 950;
  localparam int DRAIN_CYCLES = 24;
  localparam longint OWED_MAX = 64'sd2147483647;
  localparam longint OWED_MIN = -64'sd2147483648;
  localparam longint RUN_MAX = 64'sd4294967295;

  // One pending scheduling beat; the hold flag makes the sender wait for every grant first.
  typedef struct {
    bit         hold_for_drain;
    logic [3:0] slice;
  } sched_beat_t;

  // One predicted grant.
  typedef struct {
    idx_t       winner;
    logic [3:0] slice;
    run_t       total;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic [3:0]  slice_length = '0;
  logic        busy;
  logic        done;
  logic [3:0]  granted_task;
  logic [3:0]  granted_slice;
  logic [31:0] task_run_total;

  // Model of the task table and the active-count register.
  owed_t      owed_model [MAX_TASKS];
  run_t       run_model [MAX_TASKS];
  logic [4:0] share_cnt_cfg = 5'd10;

  sched_beat_t beat_q[$];
  grant_t      grant_q[$];
  int          beats_queued = 0;
  int          beats_taken = 0;
  int          grants_seen = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  bit          steady_mode = 1'b0;

  fair_share_task_picker uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .start          (start),
    .slice_length   (slice_length),
    .busy           (busy),
    .done           (done),
    .granted_task   (granted_task),
    .granted_slice  (granted_slice),
    .task_run_total (task_run_total)
  );

  always #10 clk = ~clk;

  // Pick the active task with the largest owed time, then charge it and credit the others.
  function automatic grant_t pick_and_charge(input logic [3:0] slice);
    int     n;
    int     j;
    int     pick;
    longint best;
    longint v;
    longint sum;
    grant_t g;
    n = int'(share_cnt_cfg);
    if (n == 0) n = 1;
    if (n > MAX_TASKS) n = MAX_TASKS;
    pick = 0;
    best = -1;
    for (j = 0; j < n; j++) begin
      if (longint'(owed_model[j]) > best) begin
        best = longint'(owed_model[j]);
        pick = j;
      end
    end
    for (j = 0; j < n; j++) begin
      v = longint'(owed_model[j]) + longint'(slice);
      if (j == pick) v = v - longint'(slice) * longint'(n);
      if (v > OWED_MAX) v = OWED_MAX;
      if (v < OWED_MIN) v = OWED_MIN;
      owed_model[j] = owed_t'(v);
    end
    sum = longint'(run_model[pick]) + longint'(slice);
    if (sum > RUN_MAX) sum = RUN_MAX;
    run_model[pick] = run_t'(sum);
    g.winner = idx_t'(pick);
    g.slice = slice;
    g.total = run_model[pick];
    return g;
  endfunction

  // Sender: bursts of beats separated by random gaps, or by none in steady mode.
  always @(posedge clk) begin : driver
    logic fire;
    logic go;
    fire = start && !busy;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
      slice_length <= '0;
    end else begin
      if (fire) begin
        grant_q.push_back(pick_and_charge(slice_length));
        void'(beat_q.pop_front());
        beats_taken <= beats_taken + 1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 7);
          gap_left = steady_mode ? 0 : $urandom_range(1, 40);
        end
      end
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (beat_q.size() > 0) begin
          // A held beat goes out only once every grant has come back.
          go = !beat_q[0].hold_for_drain || (!fire && beats_taken == grants_seen && !busy);
        end
        start <= go;
        if (go) slice_length <= beat_q[0].slice;
      end
    end
  end

  // Receiver: every done pulse is one grant, compared with the oldest prediction.
  always @(posedge clk) begin : monitor
    grant_t want;
    if (!rst && done) begin
      grants_seen <= grants_seen + 1;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected grant task %0d slice %0d total %0d", $time,
                 granted_task, granted_slice, task_run_total);
        mismatches++;
      end else begin
        want = grant_q.pop_front();
        if (granted_task !== want.winner) begin
          $display("%0t: granted_task expected %0d actual %0d", $time, want.winner,
                   granted_task);
          mismatches++;
        end
        if (granted_slice !== want.slice) begin
          $display("%0t: granted_slice expected %0d actual %0d", $time, want.slice,
                   granted_slice);
          mismatches++;
        end
        if (task_run_total !== want.total) begin
          $display("%0t: task_run_total expected %0d actual %0d", $time, want.total,
                   task_run_total);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fair_share_task_picker test failed");
      $finish;
    end
  end

  task automatic queue_beat(input bit hold, input logic [3:0] slice);
    sched_beat_t b;
    b.hold_for_drain = hold;
    b.slice = slice;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // Wait until every queued beat has been taken and every grant has come back.
  task automatic settle();
    @(negedge clk);
    while (beats_taken != beats_queued || grants_seen != beats_taken || busy) @(negedge clk);
  endtask

  task automatic set_share_count(input logic [4:0] value);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    share_cnt_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          j;
    int          n;
    int          pick;
    logic [4:0]  value;
    for (j = 0; j < MAX_TASKS; j++) begin
      owed_model[j] = '0;
      run_model[j] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default count of ten: ties at reset, zero slice, both slice extremes.
    steady_mode = 1'b1;
    queue_beat(1'b0, 4'd0);
    queue_beat(1'b0, 4'd15);
    queue_beat(1'b0, 4'd1);
    queue_beat(1'b0, 4'd8);
    queue_beat(1'b1, 4'd7);
    queue_beat(1'b0, 4'd15);
    queue_beat(1'b0, 4'd2);
    // A count of zero acts as one task.
    set_share_count(5'd0);
    queue_beat(1'b0, 4'd5);
    queue_beat(1'b0, 4'd10);
    // A count above the table acts as the full table.
    steady_mode = 1'b0;
    set_share_count(5'd31);
    queue_beat(1'b0, 4'd15);
    queue_beat(1'b0, 4'd15);
    queue_beat(1'b0, 4'd3);
    // Two tasks, then one: task 0 ends up owing negative time and is still granted.
    set_share_count(5'd2);
    queue_beat(1'b0, 4'd4);
    queue_beat(1'b0, 4'd9);
    queue_beat(1'b0, 4'd6);
    set_share_count(5'd1);
    queue_beat(1'b0, 4'd6);
    queue_beat(1'b0, 4'd1);
    set_share_count(5'd17);
    queue_beat(1'b0, 4'd11);
    queue_beat(1'b0, 4'd14);
    set_share_count(5'd16);
    queue_beat(1'b0, 4'd12);
    queue_beat(1'b1, 4'd13);
    queue_beat(1'b0, 4'd15);

    // Random phases, each with its own active count and idling style.
    n = beats_queued + RANDOM_BEATS;
    while (beats_queued < n) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          value = 5'd0;
        end
        1: begin
          value = 5'd1;
        end
        2: begin
          value = 5'd16;
        end
        3: begin
          value = 5'd31;
        end
        4: begin
          value = 5'($urandom_range(17, 31));
        end
        default: begin
          value = 5'($urandom_range(2, 15));
        end
      endcase
      set_share_count(value);
      steady_mode = ($urandom_range(0, 3) == 0);
      for (j = $urandom_range(30, 90); j > 0 && beats_queued < n; j--) begin
        queue_beat($urandom_range(0, 29) == 0,
                   ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 15)));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (grant_q.size() != 0) begin
      $display("%0t: %0d grants expected but never seen", $time, grant_q.size());
    end
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("fair_share_task_picker test passed");
    end else begin
      $display("fair_share_task_picker test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/fstp_pkg.sv
sv/fstp_cell.sv
sv/fair_share_task_picker.sv
dv/fair_share_task_picker_tb.sv
